[sv/vwcm_pkg.sv]
// Shared types, codes and reset constants for the vibration wash cycle monitor.
package vwcm_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_OFF      = 3'd0;
  localparam status_t ST_WASHING  = 3'd1;
  localparam status_t ST_SPINNING = 3'd2;
  localparam status_t ST_EXTERNAL = 3'd3;
  localparam status_t ST_FINISHED = 3'd4;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SPIN_THRESHOLD = 3'd0;
  localparam cfg_idx_t CFG_WASH_THRESHOLD = 3'd1;
  localparam cfg_idx_t CFG_SIGNATURE_X    = 3'd2;
  localparam cfg_idx_t CFG_SIGNATURE_Y    = 3'd3;
  localparam cfg_idx_t CFG_SIGNATURE_Z    = 3'd4;
  localparam cfg_idx_t CFG_TOLERANCE      = 3'd5;
  localparam cfg_idx_t CFG_FINISH_TIMEOUT = 3'd6;

  localparam logic [15:0] RST_SPIN_THRESHOLD = 16'd65535;
  localparam logic [15:0] RST_WASH_THRESHOLD = 16'd65535;
  localparam logic [15:0] RST_SIGNATURE      = 16'd21845;
  localparam logic [15:0] RST_TOLERANCE      = 16'd6554;
  localparam logic [31:0] RST_FINISH_TIMEOUT = 32'd300000;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [15:0] spin_threshold;
    logic [15:0] wash_threshold;
    logic [15:0] signature_x;
    logic [15:0] signature_y;
    logic [15:0] signature_z;
    logic [15:0] match_tolerance;
    logic [31:0] finish_timeout_ms;
  } vwcm_cfg_t;

  // One classified sample, handed from the front end to the state tracker.
  typedef struct packed {
    logic        loud_spin;
    logic        loud_wash;
    logic        shares_match;
    logic [31:0] now_ms;
  } vwcm_item_t;

endpackage

[sv/vwcm_front.sv]
// Front end: accepts samples, compares magnitude to thresholds and checks axis shares.
module vwcm_front
  import vwcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  vwcm_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] magnitude,
  input  logic [15:0] delta_x,
  input  logic [15:0] delta_y,
  input  logic [15:0] delta_z,
  input  logic [31:0] now_ms,
  output logic        push_valid,
  input  logic        push_ready,
  output vwcm_item_t  push_item
);

  logic        adv;

  // Stage 1: delta sum and threshold compares.
  logic        s1_v_r;
  logic [17:0] s1_sum_r;
  logic [15:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic [31:0] s1_now_r;
  logic        s1_spin_r, s1_wash_r;

  // Stage 2: cross products.
  logic        s2_v_r;
  logic [33:0] s2_px_r, s2_py_r, s2_pz_r, s2_pt_r;
  logic [15:0] s2_dx_r, s2_dy_r, s2_dz_r;
  logic        s2_nz_r;
  logic [31:0] s2_now_r;
  logic        s2_spin_r, s2_wash_r;

  logic        close_x, close_y, close_z;

  function automatic logic axis_close(input logic [15:0] d, input logic [33:0] prod,
                                      input logic [33:0] tol_prod);
    logic [33:0] a;
    logic [33:0] diff;
    a    = {2'b00, d, 16'h0000};
    diff = (a > prod) ? (a - prod) : (prod - a);
    return diff < tol_prod;
  endfunction

  assign adv      = !s2_v_r || push_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r  <= 18'(delta_x) + 18'(delta_y) + 18'(delta_z);
      s1_dx_r   <= delta_x;
      s1_dy_r   <= delta_y;
      s1_dz_r   <= delta_z;
      s1_now_r  <= now_ms;
      s1_spin_r <= magnitude > cfg.spin_threshold;
      s1_wash_r <= magnitude > cfg.wash_threshold;

      s2_px_r   <= 34'(cfg.signature_x) * 34'(s1_sum_r);
      s2_py_r   <= 34'(cfg.signature_y) * 34'(s1_sum_r);
      s2_pz_r   <= 34'(cfg.signature_z) * 34'(s1_sum_r);
      s2_pt_r   <= 34'(cfg.match_tolerance) * 34'(s1_sum_r);
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_dz_r   <= s1_dz_r;
      s2_nz_r   <= s1_sum_r != 18'd0;
      s2_now_r  <= s1_now_r;
      s2_spin_r <= s1_spin_r;
      s2_wash_r <= s1_wash_r;
    end
  end

  assign close_x = axis_close(s2_dx_r, s2_px_r, s2_pt_r);
  assign close_y = axis_close(s2_dy_r, s2_py_r, s2_pt_r);
  assign close_z = axis_close(s2_dz_r, s2_pz_r, s2_pt_r);

  assign push_valid             = s2_v_r;
  assign push_item.loud_spin    = s2_spin_r;
  assign push_item.loud_wash    = s2_wash_r;
  assign push_item.shares_match = s2_nz_r && close_x && close_y && close_z;
  assign push_item.now_ms       = s2_now_r;

endmodule

[sv/vwcm_fifo.sv]
// Short queue of classified samples between the front end and the state tracker.
module vwcm_fifo
  import vwcm_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  vwcm_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output vwcm_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  vwcm_item_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[sv/vwcm_back.sv]
// State tracker: applies each classified sample to the cycle state and holds the result word.
module vwcm_back
  import vwcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] finish_timeout_ms,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  vwcm_item_t  pop_item,
  output logic        out_valid,
  input  logic        out_ready,
  output status_t     machine_status,
  output logic        status_changed,
  output logic        report_status
);

  status_t     cur_r, cur_nxt;
  logic [31:0] stop_time_r, stop_time_nxt;
  logic        armed_r, armed_nxt;
  logic        out_v_r;
  status_t     out_status_r;
  logic        out_changed_r, out_report_r;
  logic        take;
  logic [31:0] elapsed;

  assign pop_ready = !out_v_r || out_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    cur_nxt       = cur_r;
    stop_time_nxt = stop_time_r;
    armed_nxt     = armed_r;
    elapsed       = '0;
    if (pop_item.loud_spin) begin
      cur_nxt   = pop_item.shares_match ? ST_SPINNING : ST_EXTERNAL;
      armed_nxt = 1'b0;
    end else if (pop_item.loud_wash) begin
      cur_nxt   = ST_WASHING;
      armed_nxt = 1'b0;
    end else if (cur_r == ST_WASHING || cur_r == ST_SPINNING) begin
      // The first quiet sample latches the stop time; later ones measure from it.
      if (!armed_r) begin
        stop_time_nxt = pop_item.now_ms;
      end
      armed_nxt = 1'b1;
      elapsed   = pop_item.now_ms - stop_time_nxt;
      if (elapsed > finish_timeout_ms) begin
        cur_nxt = ST_FINISHED;
      end
    end else if (cur_r != ST_FINISHED) begin
      cur_nxt = ST_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= ST_OFF;
      stop_time_r <= '0;
      armed_r     <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (take) begin
        cur_r       <= cur_nxt;
        stop_time_r <= stop_time_nxt;
        armed_r     <= armed_nxt;
        out_v_r     <= 1'b1;
      end else if (out_ready) begin
        out_v_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status_r  <= cur_nxt;
      out_changed_r <= cur_nxt != cur_r;
      out_report_r  <= (cur_nxt != cur_r) && (cur_nxt != ST_EXTERNAL);
    end
  end

  assign out_valid      = out_v_r;
  assign machine_status = out_status_r;
  assign status_changed = out_changed_r;
  assign report_status  = out_report_r;

`ifndef SYNTH
  a_report_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_report_r |-> out_changed_r)
    else $error("report flagged without a status change");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_status_r <= ST_FINISHED)
    else $error("result status out of range");

  a_armed_state: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (cur_r == ST_WASHING || cur_r == ST_SPINNING || cur_r == ST_FINISHED))
    else $error("stop timer armed outside a wash or spin cycle");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_status_r == cur_r)
    else $error("result word does not match tracked status");
`endif

endmodule

[sv/vibration_wash_cycle_monitor.sv]
// Top level of the vibration wash cycle monitor: register file, front end, queue and tracker.
//
// The monitor takes one vibration sample word per clock unless a full queue holds it back,
// and returns one status word per sample, in order. A sample whose magnitude is above
// spin_threshold is reported as spinning when every axis's share of the delta sum lies
// strictly within match_tolerance of its stored signature (a zero delta sum never matches),
// and as external vibration otherwise. A sample above wash_threshold only is washing. The
// first quiet sample after washing or spinning latches its timestamp; once a later quiet
// sample sees more than finish_timeout_ms elapsed (modulo 2^32), the status becomes
// finished and holds until the next loud sample. Other quiet samples give off. Sustained
// rate is one sample word per clock while the result side keeps up. From acceptance to the
// result word a sample passes the first front-end stage (delta sum and threshold compares),
// the second stage (the 16 by 18 bit cross products, whose share compare feeds the queue),
// the queue and the tracker's output register. The FIFO_DEPTH-entry queue lets the front
// end keep accepting while the result side is stalled. Configuration writes are always
// accepted and must be made only while no sample is in flight; writes to indexes above six
// are ignored.
module vibration_wash_cycle_monitor
  import vwcm_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] magnitude, [31:16] delta_x, [47:32] delta_y, [63:48] delta_z, [95:64] now_ms
  input  logic [95:0] in_tdata,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] machine_status, [3] status_changed, [4] report_status, [7:5] zero
  output logic [7:0]  out_tdata,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_data
);

  vwcm_cfg_t  cfg_r;
  logic       push_valid, push_ready;
  vwcm_item_t push_item;
  logic       pop_valid, pop_ready;
  vwcm_item_t pop_item;
  status_t    machine_status;
  logic       status_changed, report_status;

  // Register file; 16-bit registers keep the low half of the written word.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spin_threshold    <= RST_SPIN_THRESHOLD;
      cfg_r.wash_threshold    <= RST_WASH_THRESHOLD;
      cfg_r.signature_x       <= RST_SIGNATURE;
      cfg_r.signature_y       <= RST_SIGNATURE;
      cfg_r.signature_z       <= RST_SIGNATURE;
      cfg_r.match_tolerance   <= RST_TOLERANCE;
      cfg_r.finish_timeout_ms <= RST_FINISH_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPIN_THRESHOLD: cfg_r.spin_threshold    <= cfg_data[15:0];
        CFG_WASH_THRESHOLD: cfg_r.wash_threshold    <= cfg_data[15:0];
        CFG_SIGNATURE_X:    cfg_r.signature_x       <= cfg_data[15:0];
        CFG_SIGNATURE_Y:    cfg_r.signature_y       <= cfg_data[15:0];
        CFG_SIGNATURE_Z:    cfg_r.signature_z       <= cfg_data[15:0];
        CFG_TOLERANCE:      cfg_r.match_tolerance   <= cfg_data[15:0];
        CFG_FINISH_TIMEOUT: cfg_r.finish_timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each sample without looking at the cycle state.
  vwcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .magnitude  (in_tdata[15:0]),
    .delta_x    (in_tdata[31:16]),
    .delta_y    (in_tdata[47:32]),
    .delta_z    (in_tdata[63:48]),
    .now_ms     (in_tdata[95:64]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  vwcm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The tracker owns cycle state and applies one classified sample per clock unless stalled.
  vwcm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .finish_timeout_ms (cfg_r.finish_timeout_ms),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_item          (pop_item),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .machine_status    (machine_status),
    .status_changed    (status_changed),
    .report_status     (report_status)
  );

  assign out_tdata = {3'b000, report_status, status_changed, machine_status};

endmodule
